### design/ttrm_pkg.sv
// Package for the TCP timestamp RTT matcher: word types, table entry layout,
// state encoding, register indexes and reset constants. No dependencies.
package ttrm_pkg;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        has_timestamp;
      logic [31:0] ts_value;
      logic [31:0] ts_echo;
      logic [47:0] now_time;
   } req_type;

   typedef struct packed {
      logic        rtt_valid;
      logic [47:0] rtt_value;
      logic [47:0] report_time;
      logic        insert_dropped;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] addrs;
      logic [31:0] ports;
      logic [31:0] stamp;
      logic [47:0] stored_time;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_HIT,
      ST_INSERT,
      ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      CSR_EXPIRE_AGE,
      CSR_SWEEP_INTERVAL
   } csr_index_type;

   localparam logic [39:0] ExpireAgeReset     = 40'd180000000;
   localparam logic [39:0] SweepIntervalReset = 40'd60000000;

   // Time since an earlier stamp, zero when the clock appears to run backwards.
   function automatic logic [47:0] elapsed(input logic [47:0] now_t,
                                           input logic [47:0] then_t);
      elapsed = (now_t >= then_t) ? (now_t - then_t) : 48'd0;
   endfunction

endpackage

### design/tcp_timestamp_rtt_matcher_top.sv
// Top level of the TCP timestamp RTT matcher: scan engine around one table RAM.
// Depends on ttrm_pkg and ttrm_ram.
//
// Usage:
// The req channel carries one packet header summary per word; the rsp channel
// returns exactly one word per request with the RTT result and a drop flag.
// Both channels use valid/ready. The csr port writes expire_age (index 0)
// and sweep_interval (index 1). The user must write them only while the
// block is idle; the block itself does not enforce this. Each request walks
// the whole flow table in RAM, one entry per cycle, to find the echo match,
// the forward key, a free slot and, when a sweep is due, stale entries.
// Then it frees the hit and writes the insert. The walk goes over the single
// table read port. A new request is taken only once the result of the last
// one is loaded into the output register, when req_ready rises again.
// After reset the whole table is cleared with req_ready low.
// A stalled rsp word sits in the output register; the next request is
// accepted and walked meanwhile, and waits only before its result loads.
module tcp_timestamp_rtt_matcher_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttrm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_addr,
   input  logic [39:0]       csr_wdata
);
   import ttrm_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [IW:0] CountEnd  = (IW+1)'(TABLE_DEPTH);
   localparam logic [IW:0] CountLast = (IW+1)'(TABLE_DEPTH - 1);

   state_type   state_ff, state_in;
   logic [IW:0] cnt_ff, cnt_in;
   logic        pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0] pipe_idx_ff, pipe_idx_in;
   req_type     item_ff, item_in;
   logic        sweep_ff, sweep_in;
   logic [47:0] last_sweep_ff, last_sweep_in;
   logic [39:0] expire_age_ff, expire_age_in;
   logic [39:0] sweep_interval_ff, sweep_interval_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0] hit_time_ff, hit_time_in;
   logic        fwd_ff, fwd_in;
   logic [IW-1:0] fwd_idx_ff, fwd_idx_in;
   logic        free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;
   logic [EntryWidth-1:0] ram_rbits;

   logic [63:0] fwd_addrs, rev_addrs;
   logic [31:0] fwd_ports, rev_ports;
   logic        want_insert;
   logic        rev_match, fwd_match, is_free, is_stale;

   ttrm_ram #(.WIDTH(EntryWidth), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   assign fwd_addrs   = {item_ff.src_addr, item_ff.dst_addr};
   assign rev_addrs   = {item_ff.dst_addr, item_ff.src_addr};
   assign fwd_ports   = {item_ff.src_port, item_ff.dst_port};
   assign rev_ports   = {item_ff.dst_port, item_ff.src_port};
   assign want_insert = item_ff.has_timestamp && (item_ff.ts_value != 32'd0);

   // Per-entry decisions for the word that comes back from the RAM this cycle.
   assign rev_match = item_ff.has_timestamp && ram_rdata.valid &&
                      ram_rdata.addrs == rev_addrs && ram_rdata.ports == rev_ports &&
                      ram_rdata.stamp == item_ff.ts_echo;
   assign fwd_match = want_insert && ram_rdata.valid &&
                      ram_rdata.addrs == fwd_addrs && ram_rdata.ports == fwd_ports &&
                      ram_rdata.stamp == item_ff.ts_value;
   assign is_free   = !ram_rdata.valid;
   assign is_stale  = sweep_ff && ram_rdata.valid &&
                      elapsed(item_ff.now_time, ram_rdata.stored_time) >
                      {8'd0, expire_age_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         cnt_ff            <= '0;
         pipe_vld_ff       <= 1'b0;
         last_sweep_ff     <= '0;
         expire_age_ff     <= ExpireAgeReset;
         sweep_interval_ff <= SweepIntervalReset;
         rsp_valid_ff      <= 1'b0;
         hit_ff            <= 1'b0;
         fwd_ff            <= 1'b0;
         free_ff           <= 1'b0;
         sweep_ff          <= 1'b0;
      end else begin
         state_ff          <= state_in;
         cnt_ff            <= cnt_in;
         pipe_vld_ff       <= pipe_vld_in;
         last_sweep_ff     <= last_sweep_in;
         expire_age_ff     <= expire_age_in;
         sweep_interval_ff <= sweep_interval_in;
         rsp_valid_ff      <= rsp_valid_in;
         hit_ff            <= hit_in;
         fwd_ff            <= fwd_in;
         free_ff           <= free_in;
         sweep_ff          <= sweep_in;
      end
      pipe_idx_ff <= pipe_idx_in;
      item_ff     <= item_in;
      hit_idx_ff  <= hit_idx_in;
      hit_time_ff <= hit_time_in;
      fwd_idx_ff  <= fwd_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      pipe_vld_in       = 1'b0;
      pipe_idx_in       = pipe_idx_ff;
      item_in           = item_ff;
      sweep_in          = sweep_ff;
      last_sweep_in     = last_sweep_ff;
      expire_age_in     = expire_age_ff;
      sweep_interval_in = sweep_interval_ff;
      hit_in            = hit_ff;
      hit_idx_in        = hit_idx_ff;
      hit_time_in       = hit_time_ff;
      fwd_in            = fwd_ff;
      fwd_idx_in        = fwd_idx_ff;
      free_in           = free_ff;
      free_idx_in       = free_idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;
      ram_we            = 1'b0;
      ram_waddr         = '0;
      ram_wdata         = '0;
      ram_re            = 1'b0;
      ram_raddr         = cnt_ff[IW-1:0];
      req_ready         = 1'b0;

      if (csr_we) begin
         if (csr_addr == CSR_EXPIRE_AGE) begin
            expire_age_in = csr_wdata;
         end else begin
            sweep_interval_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[IW-1:0];
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CountLast) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               cnt_in   = '0;
               hit_in   = 1'b0;
               fwd_in   = 1'b0;
               free_in  = 1'b0;
               sweep_in = elapsed(req_data.now_time, last_sweep_ff) >
                          {8'd0, sweep_interval_ff};
               if (sweep_in) begin
                  last_sweep_in = req_data.now_time;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CountEnd) begin
               ram_re      = 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff[IW-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (pipe_vld_ff) begin
               if (rev_match) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = pipe_idx_ff;
                  hit_time_in = ram_rdata.stored_time;
               end
               if (fwd_match) begin
                  fwd_in     = 1'b1;
                  fwd_idx_in = pipe_idx_ff;
               end
               if (is_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
               // A stale entry is invalidated in place; the read side is
               // already one index ahead, so the two never collide.
               if (is_stale) begin
                  ram_we    = 1'b1;
                  ram_waddr = pipe_idx_ff;
               end
            end else if (cnt_ff == CountEnd) begin
               state_in = ST_FREE_HIT;
            end
         end
         ST_FREE_HIT: begin
            if (hit_ff) begin
               ram_we    = 1'b1;
               ram_waddr = hit_idx_ff;
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            // The key's own slot first, then a slot that was already free,
            // then the slot just released by the hit.
            if (want_insert && (fwd_ff || free_ff || hit_ff)) begin
               ram_we                = 1'b1;
               ram_waddr             = fwd_ff ? fwd_idx_ff :
                                       (free_ff ? free_idx_ff : hit_idx_ff);
               ram_wdata.valid       = 1'b1;
               ram_wdata.addrs       = fwd_addrs;
               ram_wdata.ports       = fwd_ports;
               ram_wdata.stamp       = item_ff.ts_value;
               ram_wdata.stored_time = item_ff.now_time;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.rtt_valid      = hit_ff;
               rsp_data_in.rtt_value      = hit_ff ?
                                            elapsed(item_ff.now_time, hit_time_ff) : 48'd0;
               rsp_data_in.report_time    = hit_ff ? item_ff.now_time : 48'd0;
               rsp_data_in.insert_dropped = want_insert && !fwd_ff && !free_ff && !hit_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_rtt_when_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.rtt_valid |->
      rsp_data_ff.rtt_value == 48'd0 && rsp_data_ff.report_time == 48'd0)
      else $error("rtt fields nonzero on a miss");

   a_scan_write_needs_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && ram_we |-> sweep_ff)
      else $error("table write during scan without a sweep");

   a_pipe_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> state_ff == ST_SCAN)
      else $error("read data returned outside the scan");

   a_drop_needs_insert: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_data_ff.insert_dropped |-> !rsp_data_ff.rtt_valid)
      else $error("insert dropped although the hit released a slot");

endmodule

### design/ttrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
module ttrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### bench/tb.sv
// Self-checking bench for tcp_timestamp_rtt_matcher_top: runs directed and random
// packet words against a built-in table predictor. Depends on ttrm_pkg and the design.
`timescale 1ns / 1ps

module tb;
   import ttrm_pkg::*;

   localparam int  Depth      = 256;
   localparam int  CycleLimit = 3000000;
   localparam int  DrainWait  = Depth + 40;
   localparam logic [39:0] RegMax = 40'hFF_FFFF_FFFF;

   typedef struct {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] stamp;
   } stamp_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = '0;
   logic [39:0] csr_wdata = '0;

   // Predictor state: flow table, sweep time and register copies.
   logic        tbl_valid [Depth];
   logic [63:0] tbl_addrs [Depth];
   logic [31:0] tbl_ports [Depth];
   logic [31:0] tbl_stamp [Depth];
   logic [47:0] tbl_time  [Depth];
   logic [47:0] sweep_time;
   logic [39:0] age_limit;
   logic [39:0] sweep_period;

   req_type       packet_q [$];
   rsp_type       rtt_expected_q [$];
   stamp_rec_type open_stamps [$];

   logic [31:0] host_addr [6];
   logic [15:0] host_port [6];
   logic [47:0] clock_us;
   bit          idle_on;
   int          send_gap;
   int          rsp_hold;
   int          errors;
   int          words_sent;
   int          words_seen;
   int          hits_seen;
   int          drops_seen;
   longint      cycle_count;

   tcp_timestamp_rtt_matcher_top #(.TABLE_DEPTH(Depth)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [47:0] age_of(logic [47:0] now_t, logic [47:0] then_t);
      return (now_t >= then_t) ? now_t - then_t : 48'd0;
   endfunction

   function automatic int find_slot(logic [63:0] a, logic [31:0] p, logic [31:0] s);
      for (int i = 0; i < Depth; i++)
         if (tbl_valid[i] && tbl_addrs[i] == a && tbl_ports[i] == p && tbl_stamp[i] == s)
            return i;
      return -1;
   endfunction

   task automatic predict_rtt(input req_type p);
      rsp_type     r;
      int          slot;
      logic [63:0] fwd_a;
      logic [31:0] fwd_p;
      r = '0;
      fwd_a = {p.src_addr, p.dst_addr};
      fwd_p = {p.src_port, p.dst_port};
      if (p.has_timestamp) begin
         slot = find_slot({p.dst_addr, p.src_addr}, {p.dst_port, p.src_port}, p.ts_echo);
         if (slot >= 0) begin
            r.rtt_valid = 1'b1;
            r.rtt_value = age_of(p.now_time, tbl_time[slot]);
            r.report_time = p.now_time;
            tbl_valid[slot] = 1'b0;
         end
         if (p.ts_value != 0) begin
            slot = find_slot(fwd_a, fwd_p, p.ts_value);
            if (slot < 0)
               for (int k = 0; k < Depth; k++)
                  if (!tbl_valid[k]) begin
                     slot = k;
                     break;
                  end
            if (slot >= 0) begin
               tbl_valid[slot] = 1'b1;
               tbl_addrs[slot] = fwd_a;
               tbl_ports[slot] = fwd_p;
               tbl_stamp[slot] = p.ts_value;
               tbl_time[slot] = p.now_time;
            end else begin
               r.insert_dropped = 1'b1;
            end
         end
      end
      if (age_of(p.now_time, sweep_time) > {8'd0, sweep_period}) begin
         sweep_time = p.now_time;
         for (int i = 0; i < Depth; i++)
            if (tbl_valid[i] && age_of(p.now_time, tbl_time[i]) > {8'd0, age_limit})
               tbl_valid[i] = 1'b0;
      end
      rtt_expected_q.push_back(r);
   endtask

   // Sender: one word at a time from the pending queue, with a drawn gap after each.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_rtt(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (packet_q.size() > 0) begin
               req_data <= packet_q.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_on ? $urandom_range(0, 3) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each word against the oldest expectation, stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (rtt_expected_q.size() == 0) begin
               errors++;
               $display("%0t unexpected word: expected none, actual %p", $time, rsp_data);
            end else begin
               rsp_type e;
               e = rtt_expected_q.pop_front();
               if (e.rtt_valid) hits_seen++;
               if (e.insert_dropped) drops_seen++;
               if (rsp_data.rtt_valid !== e.rtt_valid) begin
                  errors++;
                  $display("%0t rtt_valid: expected %0d, actual %0d",
                           $time, e.rtt_valid, rsp_data.rtt_valid);
               end
               if (rsp_data.rtt_value !== e.rtt_value) begin
                  errors++;
                  $display("%0t rtt_value: expected %0d, actual %0d",
                           $time, e.rtt_value, rsp_data.rtt_value);
               end
               if (rsp_data.report_time !== e.report_time) begin
                  errors++;
                  $display("%0t report_time: expected %0d, actual %0d",
                           $time, e.report_time, rsp_data.report_time);
               end
               if (rsp_data.insert_dropped !== e.insert_dropped) begin
                  errors++;
                  $display("%0t insert_dropped: expected %0d, actual %0d",
                           $time, e.insert_dropped, rsp_data.insert_dropped);
               end
            end
            rsp_hold = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_packet(logic [31:0] s, logic [31:0] d, logic [15:0] sp,
                                           logic [15:0] dp, logic ts, logic [31:0] v,
                                           logic [31:0] e, logic [47:0] t);
      req_type p;
      p.src_addr = s;
      p.dst_addr = d;
      p.src_port = sp;
      p.dst_port = dp;
      p.has_timestamp = ts;
      p.ts_value = v;
      p.ts_echo = e;
      p.now_time = t;
      return p;
   endfunction

   function automatic logic [31:0] nonzero32();
      logic [31:0] v;
      v = $urandom;
      return (v == 0) ? 32'd1 : v;
   endfunction

   task automatic record_stamp(input req_type p);
      stamp_rec_type s;
      s.src = p.src_addr;
      s.dst = p.dst_addr;
      s.sport = p.src_port;
      s.dport = p.dst_port;
      s.stamp = p.ts_value;
      open_stamps.push_back(s);
      if (open_stamps.size() > 400) void'(open_stamps.pop_front());
   endtask

   // Mostly well-formed exchanges between a few hosts: stamps sent one way are
   // echoed back later. The rest is option-less, zero-value and random noise.
   task automatic add_random(input int n, input int step_max);
      req_type       p;
      stamp_rec_type s;
      int            kind, a, b, k;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         if ($urandom_range(0, 49) == 0)
            clock_us = clock_us - $urandom_range(0, 4 * step_max + 1);
         else
            clock_us = clock_us + $urandom_range(0, step_max);
         a = $urandom_range(0, 5);
         b = $urandom_range(0, 5);
         p = make_packet(host_addr[a], host_addr[b], host_port[a], host_port[b],
                         1'b1, nonzero32(), $urandom, clock_us);
         if (kind < 55 && open_stamps.size() > 0) begin
            k = $urandom_range(0, open_stamps.size() - 1);
            s = open_stamps[k];
            open_stamps.delete(k);
            p = make_packet(s.dst, s.src, s.dport, s.sport, 1'b1, nonzero32(), s.stamp,
                            clock_us);
            if ($urandom_range(0, 9) == 0) p.ts_value = 0;
            else record_stamp(p);
         end else if (kind < 82) begin
            // Occasionally repeat a live stamp to overwrite its entry in place.
            if ($urandom_range(0, 9) == 0 && open_stamps.size() > 0) begin
               s = open_stamps[$urandom_range(0, open_stamps.size() - 1)];
               p = make_packet(s.src, s.dst, s.sport, s.dport, 1'b1, s.stamp, $urandom,
                               clock_us);
            end else begin
               record_stamp(p);
            end
         end else if (kind < 89) begin
            p.has_timestamp = 1'b0;
            if (open_stamps.size() > 0) begin
               s = open_stamps[$urandom_range(0, open_stamps.size() - 1)];
               p = make_packet(s.dst, s.src, s.dport, s.sport, 1'b0, $urandom, s.stamp,
                               clock_us);
            end
         end else if (kind < 94) begin
            p.ts_value = 0;
         end else begin
            p = make_packet($urandom, $urandom, $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 1), $urandom,
                            $urandom, clock_us);
         end
         packet_q.push_back(p);
      end
   endtask

   // Sampled on the falling edge so the sender's updates from the rising edge are seen.
   task automatic wait_drained();
      do @(negedge clock);
      while (packet_q.size() > 0 || req_valid || rtt_expected_q.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [39:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      if (idx == CSR_EXPIRE_AGE) age_limit = value;
      else sweep_period = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [31:0] ha, hb;
      logic [15:0] pa, pb;
      errors = 0;
      words_sent = 0;
      words_seen = 0;
      hits_seen = 0;
      drops_seen = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
      sweep_time = '0;
      age_limit = ExpireAgeReset;
      sweep_period = SweepIntervalReset;
      for (int i = 0; i < 6; i++) begin
         host_addr[i] = $urandom;
         host_port[i] = $urandom_range(0, 65535);
      end
      ha = host_addr[0];
      hb = host_addr[1];
      pa = host_port[0];
      pb = host_port[1];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset register values.
      packet_q.push_back(make_packet('0, '0, '0, '0, 1'b0, '0, '0, 48'd0));
      packet_q.push_back(make_packet('1, '1, '1, '1, 1'b1, '1, '1, 48'd100));
      // The all-ones flow is its own reverse: a hit and a reinsert into the freed slot.
      packet_q.push_back(make_packet('1, '1, '1, '1, 1'b1, '1, '1, 48'd150));
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd1, 32'd0, 48'd1000));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd1, 48'd1500));
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd7, 32'd0, 48'd2000));
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd7, 32'd0, 48'd2100));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd5, 32'd7, 48'd2500));
      // Reply that arrives earlier than its stamp reports a zero RTT.
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd9, 32'd0, 48'd3000));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd9, 48'd2900));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd12345, 48'd3000));
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd20, 32'd0, 48'd3100));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b0, 32'd0, 32'd20, 48'd3150));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd20, 48'd3180));
      // A late option-less word starts a sweep that ages out the stored stamp.
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd30, 32'd0, 48'd3200));
      packet_q.push_back(make_packet(ha, ha, pa, pa, 1'b0, 32'd0, 32'd0, 48'd200003200));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd30, 48'd200003300));
      packet_q.push_back(make_packet('0, '0, '0, '0, 1'b1, 32'h8000_0000, '1,
                                     48'd200003400));
      clock_us = 48'd200003400;
      add_random(300, 2000000);
      // The test waits here until every result is back.
      wait_drained();

      idle_on = 1'b0;
      write_reg(CSR_EXPIRE_AGE, 40'd0);
      write_reg(CSR_SWEEP_INTERVAL, 40'd0);
      add_random(250, 5);
      wait_drained();

      // Huge limits: nothing expires, so distinct inserts fill the table and drop.
      write_reg(CSR_EXPIRE_AGE, RegMax);
      write_reg(CSR_SWEEP_INTERVAL, RegMax);
      for (int i = 0; i < 300; i++) begin
         clock_us = clock_us + $urandom_range(0, 50);
         packet_q.push_back(make_packet($urandom, $urandom, $urandom_range(0, 65535),
                                        $urandom_range(0, 65535), 1'b1, nonzero32(),
                                        $urandom, clock_us));
         record_stamp(packet_q[$]);
      end
      add_random(200, 50);
      wait_drained();

      idle_on = 1'b1;
      write_reg(CSR_EXPIRE_AGE, 40'd5000);
      write_reg(CSR_SWEEP_INTERVAL, 40'd1000);
      add_random(500, 800);
      wait_drained();

      write_reg(CSR_EXPIRE_AGE, ExpireAgeReset);
      write_reg(CSR_SWEEP_INTERVAL, SweepIntervalReset);
      add_random(250, 2000000);
      // Top of the time range last, since it pins the sweep time there.
      packet_q.push_back(make_packet(ha, hb, pa, pb, 1'b1, 32'd44, 32'd0,
                                     48'hFFFF_FFFF_FFF0));
      packet_q.push_back(make_packet(hb, ha, pb, pa, 1'b1, 32'd0, 32'd44,
                                     48'hFFFF_FFFF_FFFF));
      packet_q.push_back(make_packet('1, '0, '1, '0, 1'b0, '1, '1, 48'hFFFF_FFFF_FFFF));
      wait_drained();
      repeat (DrainWait) @(posedge clock);

      $display("Sent %0d packet words over five register settings, received %0d results.",
               words_sent, words_seen);
      $display("Results included %0d RTT matches and %0d dropped inserts.",
               hits_seen, drops_seen);
      if (errors == 0 && rtt_expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, rtt_expected_q.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
